// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked, disabled while reset is asserted
`define LZ5_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked, also checked during reset
`define LZ5_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lz5sd_pkg.sv =====
// ---------------------------------------------------------------------------
// lz5sd_pkg
// Types and constants of the LZ5 sprite decompressor.
// ---------------------------------------------------------------------------
package lz5sd_pkg;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_SHORT   = 2'd1;
	localparam logic [1:0] ERR_BACKREF = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] pixels;
		logic [3:0]  pixel_count;
		logic        image_done;
		logic [1:0]  error_code;
	} out_item_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_FILL   = 6'b000100,
		S_CREAD  = 6'b001000,
		S_CWRITE = 6'b010000,
		S_FINAL  = 6'b100000
	} ctrl_state_t;

	typedef enum logic [5:0] {
		PH_CTRL      = 6'b000001,
		PH_CMD       = 6'b000010,
		PH_FILL_LEN  = 6'b000100,
		PH_FAR_LOW   = 6'b001000,
		PH_FAR_LEN   = 6'b010000,
		PH_NEAR_DIST = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		IMG_DECODING = 3'b001,
		IMG_COMPLETE = 3'b010,
		IMG_ABORTED  = 3'b100
	} img_status_t;

	typedef struct packed {
		logic       load;
		logic       decode;
		logic       finish;
		logic [1:0] finish_err;
		logic       push_fill;
		logic       rd;
		logic       push_copy;
		logic       finalize;
	} cmd_t;

	typedef struct packed {
		logic decoding;
		logic size_reached;
		logic act_fill;
		logic act_copy;
		logic dist_bad;
		logic run_done;
		logic lane_full;
		logic out_free;
		logic need_emit;
	} sts_t;

endpackage

// ===== rtl/lz5sd_ctrl.sv =====
// ---------------------------------------------------------------------------
// lz5sd_ctrl
// Sequencer: byte intake, decode, per-pixel fill/copy steps and close-out.
// ---------------------------------------------------------------------------
module lz5sd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_stall,
	input  lz5sd_pkg::sts_t sts,
	output lz5sd_pkg::cmd_t cmd
);

	lz5sd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lz5sd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign src_stall = (state_q != lz5sd_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.finish_err = lz5sd_pkg::ERR_OK;
		case (state_q)
			lz5sd_pkg::S_IDLE: begin
				if (src_valid) begin
					cmd.load = 1'b1;
					state_d  = lz5sd_pkg::S_DECODE;
				end
			end
			lz5sd_pkg::S_DECODE: begin
				if (!sts.decoding) begin
					state_d = lz5sd_pkg::S_FINAL;
				end else if (sts.size_reached) begin
					cmd.finish = 1'b1;
					state_d    = lz5sd_pkg::S_FINAL;
				end else begin
					cmd.decode = 1'b1;
					if (sts.act_fill) begin
						state_d = lz5sd_pkg::S_FILL;
					end else if (sts.act_copy && sts.dist_bad) begin
						cmd.finish     = 1'b1;
						cmd.finish_err = lz5sd_pkg::ERR_BACKREF;
						state_d        = lz5sd_pkg::S_FINAL;
					end else if (sts.act_copy) begin
						state_d = lz5sd_pkg::S_CREAD;
					end else begin
						state_d = lz5sd_pkg::S_FINAL;
					end
				end
			end
			lz5sd_pkg::S_FILL: begin
				if (sts.size_reached) begin
					cmd.finish = 1'b1;
					state_d    = lz5sd_pkg::S_FINAL;
				end else if (sts.run_done) begin
					state_d = lz5sd_pkg::S_FINAL;
				end else if (!sts.lane_full || sts.out_free) begin
					cmd.push_fill = 1'b1;
				end
			end
			lz5sd_pkg::S_CREAD: begin
				if (sts.size_reached) begin
					cmd.finish = 1'b1;
					state_d    = lz5sd_pkg::S_FINAL;
				end else if (sts.run_done) begin
					state_d = lz5sd_pkg::S_FINAL;
				end else begin
					cmd.rd  = 1'b1;
					state_d = lz5sd_pkg::S_CWRITE;
				end
			end
			lz5sd_pkg::S_CWRITE: begin
				if (!sts.lane_full || sts.out_free) begin
					cmd.push_copy = 1'b1;
					state_d       = lz5sd_pkg::S_CREAD;
				end
			end
			lz5sd_pkg::S_FINAL: begin
				if (!sts.need_emit || sts.out_free) begin
					cmd.finalize = 1'b1;
					state_d      = lz5sd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lz5sd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lz5sd_dpath.sv =====
// ---------------------------------------------------------------------------
// lz5sd_dpath
// Command parser registers, history memory, lane packer and result register.
// ---------------------------------------------------------------------------
module lz5sd_dpath #(
	parameter int HISTORY_DEPTH = 1024,
	parameter int LANES         = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  lz5sd_pkg::in_item_t  src_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output lz5sd_pkg::out_item_t res_data,
	input  lz5sd_pkg::cmd_t      cmd,
	output lz5sd_pkg::sts_t      sts
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int FW = $clog2(LANES + 1);
	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

	logic [15:0] width_q, height_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic [7:0]  ctrl_bits_q;
	logic [2:0]  ctrl_idx_q;
	logic [7:0]  hp_acc_q;
	logic [2:0]  hp_shift_q;
	logic [9:0]  pend_q;
	logic [31:0] pw_q;
	lz5sd_pkg::phase_t      phase_q;
	lz5sd_pkg::img_status_t status_q;

	logic [8:0]    run_q;
	logic [4:0]    colour_q;
	logic [AW-1:0] wp_q, rp_q;
	logic [7:0]    rd_q;
	logic [7:0]    hist [HISTORY_DEPTH];

	logic [7:0]    lane_q [LANES];
	logic [FW-1:0] fill_q;
	logic          fin_q;
	logic [1:0]    err_q;

	logic                 res_valid_q;
	lz5sd_pkg::out_item_t res_q;

	// decode results
	logic        dec_fill, dec_copy;
	logic [8:0]  dec_cnt;
	logic [4:0]  dec_colour;
	logic [10:0] dec_dist;
	logic [7:0]  ctrl_bits_n, hp_acc_n, acc_or;
	logic [2:0]  ctrl_idx_n, hp_shift_n, idx_inc;
	logic [3:0]  shift_inc;
	logic [9:0]  pend_n;
	lz5sd_pkg::phase_t phase_n, phase_end;

	logic [31:0]   total;
	logic          out_free, lane_full, abort_now, push, dist_bad;
	logic [7:0]    pix;
	logic [63:0]   packed_px;
	logic [AW+1:0] wrap_sum;
	logic [AW-1:0] rp_new, wp_inc, rp_inc;

	assign total     = width_q * height_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign lane_full = (fill_q == FW'(LANES));
	assign abort_now = last_q && (status_q == lz5sd_pkg::IMG_DECODING);
	assign push      = cmd.push_fill || cmd.push_copy;
	assign pix       = cmd.push_fill ? {3'b000, colour_q} : rd_q;
	assign dist_bad  = {21'b0, dec_dist} > pw_q;

	assign idx_inc   = ctrl_idx_q + 3'd1;
	assign phase_end = (idx_inc == 3'd0) ? lz5sd_pkg::PH_CTRL : lz5sd_pkg::PH_CMD;
	assign shift_inc = {1'b0, hp_shift_q} + 4'd2;
	assign acc_or    = hp_acc_q | ({byte_q[7:6], 6'b0} >> hp_shift_q);

	always_comb begin
		dec_fill    = 1'b0;
		dec_copy    = 1'b0;
		dec_cnt     = '0;
		dec_colour  = '0;
		dec_dist    = '0;
		ctrl_bits_n = ctrl_bits_q;
		ctrl_idx_n  = ctrl_idx_q;
		hp_acc_n    = hp_acc_q;
		hp_shift_n  = hp_shift_q;
		pend_n      = pend_q;
		phase_n     = phase_q;
		case (phase_q)
			lz5sd_pkg::PH_CMD: begin
				if (ctrl_bits_q[ctrl_idx_q]) begin
					if (byte_q[5:0] == 6'd0) begin
						pend_n  = {byte_q[7:6], 8'd0};
						phase_n = lz5sd_pkg::PH_FAR_LOW;
					end else if (shift_inc < 4'd8) begin
						hp_acc_n   = acc_or;
						hp_shift_n = shift_inc[2:0];
						pend_n     = {4'd0, byte_q[5:0]};
						phase_n    = lz5sd_pkg::PH_NEAR_DIST;
					end else begin
						dec_copy   = 1'b1;
						dec_dist   = 11'(acc_or) + 11'd1;
						dec_cnt    = 9'(byte_q[5:0]) + 9'd1;
						hp_acc_n   = '0;
						hp_shift_n = '0;
						ctrl_idx_n = idx_inc;
						phase_n    = phase_end;
					end
				end else begin
					if (byte_q[7:5] == 3'd0) begin
						pend_n  = {5'd0, byte_q[4:0]};
						phase_n = lz5sd_pkg::PH_FILL_LEN;
					end else begin
						dec_fill   = 1'b1;
						dec_colour = byte_q[4:0];
						dec_cnt    = 9'(byte_q[7:5]);
						ctrl_idx_n = idx_inc;
						phase_n    = phase_end;
					end
				end
			end
			lz5sd_pkg::PH_FILL_LEN: begin
				dec_fill   = 1'b1;
				dec_colour = pend_q[4:0];
				dec_cnt    = 9'(byte_q) + 9'd8;
				ctrl_idx_n = idx_inc;
				phase_n    = phase_end;
			end
			lz5sd_pkg::PH_FAR_LOW: begin
				pend_n  = {pend_q[9:8], byte_q};
				phase_n = lz5sd_pkg::PH_FAR_LEN;
			end
			lz5sd_pkg::PH_FAR_LEN: begin
				dec_copy   = 1'b1;
				dec_dist   = 11'(pend_q) + 11'd1;
				dec_cnt    = 9'(byte_q) + 9'd3;
				ctrl_idx_n = idx_inc;
				phase_n    = phase_end;
			end
			lz5sd_pkg::PH_NEAR_DIST: begin
				dec_copy   = 1'b1;
				dec_dist   = 11'(byte_q) + 11'd1;
				dec_cnt    = 9'(pend_q[5:0]) + 9'd1;
				ctrl_idx_n = idx_inc;
				phase_n    = phase_end;
			end
			default: begin
				ctrl_bits_n = byte_q;
				ctrl_idx_n  = '0;
				phase_n     = lz5sd_pkg::PH_CMD;
			end
		endcase
	end

	// history read pointer: write pointer minus distance, modulo depth
	assign wrap_sum = (AW+2)'(wp_q) + (AW+2)'(HISTORY_DEPTH) - (AW+2)'(dec_dist);
	assign rp_new   = ((AW+2)'(wp_q) >= (AW+2)'(dec_dist)) ?
		AW'((AW+2)'(wp_q) - (AW+2)'(dec_dist)) : AW'(wrap_sum);
	assign wp_inc   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc   = (rp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	always_comb begin
		packed_px = '0;
		for (int k = 0; k < LANES; k++) begin
			if (FW'(k) < fill_q) begin
				packed_px[8*k +: 8] = lane_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hist[wp_q] <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= hist[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= src_data.data_byte;
		end
		if (cmd.decode) begin
			run_q    <= dec_cnt;
			colour_q <= dec_colour;
			rp_q     <= rp_new;
		end else if (push) begin
			run_q <= run_q - 9'd1;
			if (cmd.push_copy) begin
				rp_q <= rp_inc;
			end
		end
		if (push) begin
			if (lane_full) begin
				lane_q[0] <= pix;
			end else begin
				lane_q[LW'(fill_q)] <= pix;
			end
		end
		if ((push && lane_full) || (cmd.finalize && sts.need_emit)) begin
			res_q.pixels      <= packed_px;
			res_q.pixel_count <= 4'(fill_q);
			res_q.image_done  <= cmd.finalize && (fin_q || abort_now);
			res_q.error_code  <= !cmd.finalize ? lz5sd_pkg::ERR_OK :
				(abort_now ? lz5sd_pkg::ERR_SHORT : err_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 16'd1;
			height_q    <= 16'd1;
			last_q      <= 1'b0;
			ctrl_bits_q <= '0;
			ctrl_idx_q  <= '0;
			hp_acc_q    <= '0;
			hp_shift_q  <= '0;
			pend_q      <= '0;
			pw_q        <= '0;
			wp_q        <= '0;
			phase_q     <= lz5sd_pkg::PH_CTRL;
			status_q    <= lz5sd_pkg::IMG_DECODING;
			fill_q      <= '0;
			fin_q       <= 1'b0;
			err_q       <= lz5sd_pkg::ERR_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					lz5sd_pkg::REG_WIDTH:  width_q  <= cfg_data;
					lz5sd_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_q <= src_data.last_byte;
			end
			if (cmd.decode) begin
				ctrl_bits_q <= ctrl_bits_n;
				ctrl_idx_q  <= ctrl_idx_n;
				hp_acc_q    <= hp_acc_n;
				hp_shift_q  <= hp_shift_n;
				pend_q      <= pend_n;
				phase_q     <= phase_n;
			end
			if (push) begin
				pw_q   <= pw_q + 32'd1;
				wp_q   <= wp_inc;
				fill_q <= lane_full ? FW'(1) : fill_q + 1'b1;
			end
			if (cmd.finish) begin
				fin_q    <= 1'b1;
				err_q    <= cmd.finish_err;
				status_q <= (cmd.finish_err == lz5sd_pkg::ERR_OK) ?
					lz5sd_pkg::IMG_COMPLETE : lz5sd_pkg::IMG_ABORTED;
			end
			if ((push && lane_full) || (cmd.finalize && sts.need_emit)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cmd.finalize) begin
				fill_q <= '0;
				fin_q  <= 1'b0;
				err_q  <= lz5sd_pkg::ERR_OK;
				if (last_q) begin
					ctrl_bits_q <= '0;
					ctrl_idx_q  <= '0;
					hp_acc_q    <= '0;
					hp_shift_q  <= '0;
					pend_q      <= '0;
					pw_q        <= '0;
					wp_q        <= '0;
					phase_q     <= lz5sd_pkg::PH_CTRL;
					status_q    <= lz5sd_pkg::IMG_DECODING;
				end
			end
		end
	end

	assign sts.decoding     = (status_q == lz5sd_pkg::IMG_DECODING);
	assign sts.size_reached = (pw_q >= total);
	assign sts.act_fill     = dec_fill;
	assign sts.act_copy     = dec_copy;
	assign sts.dist_bad     = dist_bad;
	assign sts.run_done     = (run_q == 9'd0);
	assign sts.lane_full    = lane_full;
	assign sts.out_free     = out_free;
	assign sts.need_emit    = fin_q || abort_now || (fill_q != '0);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// ===== rtl/lz5_sprite_decompressor_core.sv =====
// Sequence: a transferred byte is registered and decoded in the cycle after its transfer,
// then each fill pixel is written in a FILL step and each copy pixel takes a history memory
// read then write, followed by an end-of-run step and a close-out step. A new byte is taken
// only in idle, after the previous one closes out; a stalled result holds the sequencer while
// a full lane word or the closing result waits. Reset: arst_n clears all control state; size
// registers return to 1x1, history contents are left as they are.
// ---------------------------------------------------------------------------
// lz5_sprite_decompressor_core
// LZ5 sprite decompressor: byte stream in, packed pixel words out.
// ---------------------------------------------------------------------------
module lz5_sprite_decompressor_core #(
	parameter int HISTORY_DEPTH = 1024,
	parameter int LANES         = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  lz5sd_pkg::in_item_t  src_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output lz5sd_pkg::out_item_t res_data
);

	lz5sd_pkg::cmd_t cmd;
	lz5sd_pkg::sts_t sts;

	lz5sd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lz5sd_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.LANES         (LANES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== rtl/lz5sd_checker.sv =====
// ---------------------------------------------------------------------------
// lz5sd_checker
// Port-level checks on the result stream of the decompressor.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lz5sd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 src_valid,
	input logic                 src_stall,
	input lz5sd_pkg::in_item_t  src_data,
	input logic                 res_valid,
	input logic                 res_stall,
	input lz5sd_pkg::out_item_t res_data
);

	logic in_xfer;

	assign in_xfer = src_valid && !src_stall && (src_data.last_byte || !src_data.last_byte);

	`LZ5_ASSERT(a_count_max, clk, arst_n, res_valid |-> (res_data.pixel_count <= 4'd8), "pixel_count above 8")
	`LZ5_ASSERT(a_err_done, clk, arst_n, (res_valid && (res_data.error_code != lz5sd_pkg::ERR_OK)) |-> res_data.image_done, "error without image_done")
	`LZ5_ASSERT(a_empty_done, clk, arst_n, (res_valid && (res_data.pixel_count == 4'd0)) |-> res_data.image_done, "empty result not closing image")
	`LZ5_ASSERT(a_held, clk, arst_n, (res_valid && res_stall) |=> (res_valid && $stable(res_data)), "stalled result changed")
	`LZ5_ASSERT_NR(a_rst_idle, clk, (!arst_n || $past(in_xfer && res_stall && !res_valid)) |-> (arst_n || !res_valid), "result valid in reset")

endmodule

bind lz5_sprite_decompressor_core lz5sd_checker u_chk (.*);
